// ===== rtl/sbg_pkg.sv =====
// Shared types, constants and transform functions for the Streebog hash engine
package sbg_pkg;

  typedef logic [511:0] blk_t;

  // Controller commands to the datapath
  typedef struct packed {
    logic restart;     // load IV, clear N, sigma, block
    logic put_byte;    // write data byte at fill position
    logic put_pad;     // write 0x01 at fill position
    logic start_msg;   // compress block with N (begin)
    logic start_n;     // compress N with zero
    logic start_sig;   // compress sigma with zero
    logic round;       // one round step
    logic finish;      // chain update
    logic absorb_upd;  // update N and sigma, clear block
    logic out_load;    // latch digest for shifting
    logic out_shift;   // advance one digest byte
  } sbg_cmd_t;

  typedef struct packed {
    logic [6:0] fill;
  } sbg_sts_t;

  localparam int unsigned Rounds = 12;

  localparam logic [7:0] SBOX [256] = '{
    8'd252,8'd238,8'd221,8'd17,8'd207,8'd110,8'd49,8'd22,8'd251,8'd196,8'd250,8'd218,8'd35,8'd197,8'd4,8'd77,
    8'd233,8'd119,8'd240,8'd219,8'd147,8'd46,8'd153,8'd186,8'd23,8'd54,8'd241,8'd187,8'd20,8'd205,8'd95,8'd193,
    8'd249,8'd24,8'd101,8'd90,8'd226,8'd92,8'd239,8'd33,8'd129,8'd28,8'd60,8'd66,8'd139,8'd1,8'd142,8'd79,
    8'd5,8'd132,8'd2,8'd174,8'd227,8'd106,8'd143,8'd160,8'd6,8'd11,8'd237,8'd152,8'd127,8'd212,8'd211,8'd31,
    8'd235,8'd52,8'd44,8'd81,8'd234,8'd200,8'd72,8'd171,8'd242,8'd42,8'd104,8'd162,8'd253,8'd58,8'd206,8'd204,
    8'd181,8'd112,8'd14,8'd86,8'd8,8'd12,8'd118,8'd18,8'd191,8'd114,8'd19,8'd71,8'd156,8'd183,8'd93,8'd135,
    8'd21,8'd161,8'd150,8'd41,8'd16,8'd123,8'd154,8'd199,8'd243,8'd145,8'd120,8'd111,8'd157,8'd158,8'd178,8'd177,
    8'd50,8'd117,8'd25,8'd61,8'd255,8'd53,8'd138,8'd126,8'd109,8'd84,8'd198,8'd128,8'd195,8'd189,8'd13,8'd87,
    8'd223,8'd245,8'd36,8'd169,8'd62,8'd168,8'd67,8'd201,8'd215,8'd121,8'd214,8'd246,8'd124,8'd34,8'd185,8'd3,
    8'd224,8'd15,8'd236,8'd222,8'd122,8'd148,8'd176,8'd188,8'd220,8'd232,8'd40,8'd80,8'd78,8'd51,8'd10,8'd74,
    8'd167,8'd151,8'd96,8'd115,8'd30,8'd0,8'd98,8'd68,8'd26,8'd184,8'd56,8'd130,8'd100,8'd159,8'd38,8'd65,
    8'd173,8'd69,8'd70,8'd146,8'd39,8'd94,8'd85,8'd47,8'd140,8'd163,8'd165,8'd125,8'd105,8'd213,8'd149,8'd59,
    8'd7,8'd88,8'd179,8'd64,8'd134,8'd172,8'd29,8'd247,8'd48,8'd55,8'd107,8'd228,8'd136,8'd217,8'd231,8'd137,
    8'd225,8'd27,8'd131,8'd73,8'd76,8'd63,8'd248,8'd254,8'd141,8'd83,8'd170,8'd144,8'd202,8'd216,8'd133,8'd97,
    8'd32,8'd113,8'd103,8'd164,8'd45,8'd43,8'd9,8'd91,8'd203,8'd155,8'd37,8'd208,8'd190,8'd229,8'd108,8'd82,
    8'd89,8'd166,8'd116,8'd210,8'd230,8'd244,8'd180,8'd192,8'd209,8'd102,8'd175,8'd194,8'd57,8'd75,8'd99,8'd182
  };

  localparam logic [63:0] LROWS [64] = '{
    64'h8e20faa72ba0b470,64'h47107ddd9b505a38,64'had08b0e0c3282d1c,64'hd8045870ef14980e,
    64'h6c022c38f90a4c07,64'h3601161cf205268d,64'h1b8e0b0e798c13c8,64'h83478b07b2468764,
    64'ha011d380818e8f40,64'h5086e740ce47c920,64'h2843fd2067adea10,64'h14aff010bdd87508,
    64'h0ad97808d06cb404,64'h05e23c0468365a02,64'h8c711e02341b2d01,64'h46b60f011a83988e,
    64'h90dab52a387ae76f,64'h486dd4151c3dfdb9,64'h24b86a840e90f0d2,64'h125c354207487869,
    64'h092e94218d243cba,64'h8a174a9ec8121e5d,64'h4585254f64090fa0,64'haccc9ca9328a8950,
    64'h9d4df05d5f661451,64'hc0a878a0a1330aa6,64'h60543c50de970553,64'h302a1e286fc58ca7,
    64'h18150f14b9ec46dd,64'h0c84890ad27623e0,64'h0642ca05693b9f70,64'h0321658cba93c138,
    64'h86275df09ce8aaa8,64'h439da0784e745554,64'hafc0503c273aa42a,64'hd960281e9d1d5215,
    64'he230140fc0802984,64'h71180a8960409a42,64'hb60c05ca30204d21,64'h5b068c651810a89e,
    64'h456c34887a3805b9,64'hac361a443d1c8cd2,64'h561b0d22900e4669,64'h2b838811480723ba,
    64'h9bcf4486248d9f5d,64'hc3e9224312c8c1a0,64'heffa11af0964ee50,64'hf97d86d98a327728,
    64'he4fa2054a80b329c,64'h727d102a548b194e,64'h39b008152acb8227,64'h9258048415eb419d,
    64'h492c024284fbaec0,64'haa16012142f35760,64'h550b8e9e21f7a530,64'ha48b474f9ef5dc18,
    64'h70a6a56e2440598e,64'h3853dc371220a247,64'h1ca76e95091051ad,64'h0edd37c48a08a6d8,
    64'h07e095624504536c,64'h8d70c431ac02a736,64'hc83862965601dd1b,64'h641c314b2b8ee083
  };

  localparam blk_t ICONST [12] = '{
    512'hb1085bda1ecadae9ebcb2f81c0657c1f2f6a76432e45d016714eb88d7585c4fc4b7ce09192676901a2422a08a460d31505767436cc744d23dd806559f2a64507,
    512'h6fa3b58aa99d2f1a4fe39d460f70b5d7f3feea720a232b9861d55e0f16b501319ab5176b12d699585cb561c2db0aa7ca55dda21bd7cbcd56e679047021b19bb7,
    512'hf574dcac2bce2fc70a39fc286a3d843506f15e5f529c1f8bf2ea7514b1297b7bd3e20fe490359eb1c1c93a376062db09c2b6f443867adb31991e96f50aba0ab2,
    512'hef1fdfb3e81566d2f948e1a05d71e4dd488e857e335c3c7d9d721cad685e353fa9d72c82ed03d675d8b71333935203be3453eaa193e837f1220cbebc84e3d12e,
    512'h4bea6bacad4747999a3f410c6ca923637f151c1f1686104a359e35d7800fffbdbfcd1747253af5a3dfff00b723271a167a56a27ea9ea63f5601758fd7c6cfe57,
    512'hae4faeae1d3ad3d96fa4c33b7a3039c02d66c4f95142a46c187f9ab49af08ec6cffaa6b71c9ab7b40af21f66c2bec6b6bf71c57236904f35fa68407a46647d6e,
    512'hf4c70e16eeaac5ec51ac86febf240954399ec6c7e6bf87c9d3473e33197a93c90992abc52d822c3706476983284a05043517454ca23c4af38886564d3a14d493,
    512'h9b1f5b424d93c9a703e7aa020c6e41414eb7f8719c36de1e89b4443b4ddbc49af4892bcb929b069069d18d2bd1a5c42f36acc2355951a8d9a47f0dd4bf02e71e,
    512'h378f5a541631229b944c9ad8ec165fde3a7d3a1b258942243cd955b7e00d0984800a440bdbb2ceb17b2b8a9aa6079c540e38dc92cb1f2a607261445183235adb,
    512'habbedea680056f52382ae548b2e4f3f38941e71cff8a78db1fffe18a1b3361039fe76702af69334b7a1e6c303b7652f43698fad1153bb6c374b4c7fb98459ced,
    512'h7bcd9ed0efc889fb3002c6cd635afe94d8fa6bbbebab076120018021148466798a1d71efea48b9caefbacd1d7d476e98dea2594ac06fd85d6bcaa4cd81f32d1b,
    512'h378ee767f11631bad21380b00449b17acda43c32bcdf1d77f82012d430219f9b5d80ef9d1891cc86e71da4aa88e12852faf417d5d9b21b9948bc924af11bd720
  };

  // Linear map on one 64-bit word: XOR of rows selected by set bits
  function automatic logic [63:0] lin64(input logic [63:0] t);
    logic [63:0] acc;
    acc = '0;
    for (int p = 0; p < 64; p++) begin
      if (t[63-p]) acc = acc ^ LROWS[p];
    end
    return acc;
  endfunction

  // Full S, P and L transform; word 0 at the top of the vector
  function automatic blk_t lps(input blk_t x);
    blk_t r;
    logic [63:0] t;
    r = '0;
    for (int w = 0; w < 8; w++) begin
      t = '0;
      for (int c = 0; c < 8; c++) begin
        t[63-8*c -: 8] = SBOX[x[511-64*c-8*w -: 8]];
      end
      r[511-64*w -: 64] = lin64(t);
    end
    return r;
  endfunction

endpackage

// ===== rtl/sbg_datapath.sv =====
// Datapath: block buffer, chain value, counters, round unit and digest shifter
module sbg_datapath (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            dsz_512,
  input  logic [7:0]      data_byte,
  input  sbg_pkg::sbg_cmd_t cmd,
  output sbg_pkg::sbg_sts_t sts,
  output logic [7:0]      digest_byte
);
  import sbg_pkg::*;

  blk_t h_r, n_r, sig_r, blk_r, k_r, st_r, m_r, dig_r;
  logic [6:0] fill_r;
  logic [3:0] ridx_r;
  blk_t iv, msg_sel, wmask, wval, len, h_fin;
  logic [5:0] pos;

  assign iv  = dsz_512 ? '0 : {64{8'h01}};
  assign pos = fill_r[5:0];
  // byte i of the block sits i bytes up from the least significant end
  assign wmask = blk_t'(8'hff) << {pos, 3'b000};
  assign wval  = blk_t'(cmd.put_pad ? 8'h01 : data_byte) << {pos, 3'b000};
  // bits taken: 512 for a full block (fill 64), fill * 8 for the padded one
  assign len   = blk_t'({fill_r, 3'b000});
  assign msg_sel = cmd.start_n ? n_r : (cmd.start_sig ? sig_r : blk_r);
  // chain value after the last round: final key XOR folded in here
  assign h_fin = h_r ^ st_r ^ k_r ^ m_r;

  assign sts.fill    = fill_r;
  assign digest_byte = dig_r[511:504];

  // Fill counter and round index
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.restart) begin
      fill_r <= '0;
      ridx_r <= '0;
    end else begin
      if (cmd.put_byte) fill_r <= fill_r + 7'd1;
      if (cmd.absorb_upd) fill_r <= '0;
      if (cmd.start_msg || cmd.start_n || cmd.start_sig) ridx_r <= '0;
      else if (cmd.round) ridx_r <= ridx_r + 4'd1;
    end
  end

  // Message state
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.restart) begin
      h_r   <= iv;
      n_r   <= '0;
      sig_r <= '0;
      blk_r <= '0;
    end else begin
      if (cmd.put_byte || cmd.put_pad) blk_r <= (blk_r & ~wmask) | wval;
      if (cmd.finish) h_r <= h_fin;
      if (cmd.absorb_upd) begin
        n_r   <= n_r + len;
        sig_r <= sig_r + blk_r;
        blk_r <= '0;
      end
    end
  end

  // Round unit, one LPS on state and key per cycle, and digest shifter
  always_ff @(posedge clk) begin
    if (cmd.start_msg) begin
      k_r  <= lps(h_r ^ n_r);
      m_r  <= msg_sel;
    end else if (cmd.start_n || cmd.start_sig) begin
      k_r  <= lps(h_r);
      m_r  <= msg_sel;
    end else if (cmd.round) begin
      k_r  <= lps(k_r ^ ICONST[ridx_r]);
    end
    if (cmd.round) st_r <= lps(st_r ^ k_r);
    else if (cmd.start_msg || cmd.start_n || cmd.start_sig) st_r <= msg_sel;
    if (cmd.out_load) dig_r <= h_fin;
    else if (cmd.out_shift) dig_r <= {dig_r[503:0], 8'h00};
  end

  // note: st holds m; first round computes lps(m ^ K0); last XOR done at finish
endmodule

// ===== rtl/sbg_ctrl.sv =====
// Controller: sequences absorption, finalisation and digest output
module sbg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              dsz_512,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              byte_valid,
  input  logic              message_end,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              digest_last,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  sbg_pkg::sbg_sts_t sts,
  output sbg_pkg::sbg_cmd_t cmd
);
  import sbg_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0, S_RUN = 3'd1, S_FIN = 3'd2, S_UPD = 3'd3,
                         S_OUT = 3'd4;
  // phases: block absorption and the steps of finalisation
  localparam logic [1:0] P_ABS = 2'd0, P_PAD = 2'd1, P_N = 2'd2, P_SIG = 2'd3;

  logic [2:0] st_r, st_nxt;
  logic [1:0] ph_r, ph_nxt;
  logic       end_r, end_nxt;
  logic [3:0] rc_r, rc_nxt;
  logic [5:0] oc_r, oc_nxt;
  logic       acc;
  logic [5:0] last_idx;

  assign last_idx  = dsz_512 ? 6'd63 : 6'd31;
  // a register write takes precedence over an input word
  assign in_stall  = (st_r != S_IDLE) || cfg_valid;
  assign cfg_ready = (st_r == S_IDLE);
  assign acc       = in_valid && !in_stall;
  assign out_valid = (st_r == S_OUT);
  assign digest_last = (oc_r == last_idx);

  always_comb begin
    cmd    = '0;
    st_nxt = st_r;
    ph_nxt = ph_r;
    end_nxt = end_r;
    rc_nxt = rc_r;
    oc_nxt = oc_r;
    cmd.restart = cfg_valid && (st_r == S_IDLE);
    unique case (st_r)
      S_IDLE: begin
        if (acc) begin
          cmd.put_byte = byte_valid;
          end_nxt = message_end;
          if (byte_valid && sts.fill == 7'd63) begin
            // block complete once this byte is written; start next cycle
            ph_nxt = P_ABS; st_nxt = S_UPD;
          end else if (message_end) begin
            st_nxt = S_FIN; ph_nxt = P_PAD;
          end
        end
      end
      S_FIN: begin
        // pad the partial block and compress it
        cmd.put_pad = 1'b1;
        cmd.start_msg = 1'b0;
        st_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.start_msg = 1'b1; rc_nxt = '0; st_nxt = S_RUN;
      end
      S_RUN: begin
        if (rc_r == 4'(Rounds)) begin
          cmd.finish = 1'b1;
          unique case (ph_r)
            P_ABS: begin
              cmd.absorb_upd = 1'b1;
              if (end_r) begin st_nxt = S_FIN; ph_nxt = P_PAD; end
              else st_nxt = S_IDLE;
            end
            P_PAD: begin cmd.absorb_upd = 1'b1; ph_nxt = P_N; st_nxt = S_UPD; end
            P_N:   begin ph_nxt = P_SIG; st_nxt = S_UPD; end
            default: begin st_nxt = S_OUT; oc_nxt = '0; end
          endcase
        end else begin
          cmd.round = 1'b1; rc_nxt = rc_r + 4'd1;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          cmd.out_shift = 1'b1;
          oc_nxt = oc_r + 6'd1;
          if (oc_r == last_idx) begin cmd.restart = 1'b1; st_nxt = S_IDLE; end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
    // S_UPD start selector by phase
    if (st_r == S_UPD) begin
      cmd.start_msg = (ph_r == P_ABS) || (ph_r == P_PAD);
      cmd.start_n   = (ph_r == P_N);
      cmd.start_sig = (ph_r == P_SIG);
    end
    cmd.out_load = (st_r == S_RUN) && (rc_r == 4'(Rounds)) && (ph_r == P_SIG);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ph_r <= P_ABS; end_r <= 1'b0; rc_r <= '0; oc_r <= '0;
    end else begin
      st_r <= st_nxt; ph_r <= ph_nxt; end_r <= end_nxt; rc_r <= rc_nxt; oc_r <= oc_nxt;
    end
  end
endmodule

// ===== rtl/streebog_hash_engine.sv =====
// Top level of the Streebog hash engine
// Usage:
//  - in_ channel carries one message word per handshake: data_byte, byte_valid
//    and message_end. A word is taken when in_valid is high and in_stall low.
//  - Bytes fill a 64-byte block, one per cycle while in_stall is low; a
//    full block holds the input through start, 12 rounds and chain update,
//    one LPS pass of state and key per cycle in the round unit.
//  - message_end runs finalisation: a pad step, then three compressions
//    (padded block, g_0(N), g_0(sigma)), then 64 or 32 digest words on
//    out_, most significant first, digest_last on the final one.
//  - out_stall holds the current digest word; the input stays stalled until
//    the whole digest has gone.
//  - cfg_ writes digest_size_512 while idle and restarts the message with
//    the new IV; in_stall is high while cfg_valid is. Reset selects the
//    512-bit digest and an empty message.
module streebog_hash_engine (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_byte_valid,
  input  logic       in_message_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_digest_byte,
  output logic       out_digest_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_digest_size_512
);
  import sbg_pkg::*;

  sbg_cmd_t cmd;
  sbg_sts_t sts;
  logic     dsz_r;

  // digest size register
  always_ff @(posedge clk) begin
    if (!rst_n) dsz_r <= 1'b1;
    else if (cfg_valid && cfg_ready) dsz_r <= cfg_digest_size_512;
  end

  sbg_ctrl u_ctrl (
    .clk, .rst_n, .dsz_512(dsz_r),
    .in_valid, .in_stall, .byte_valid(in_byte_valid), .message_end(in_message_end),
    .out_valid, .out_stall, .digest_last(out_digest_last),
    .cfg_valid, .cfg_ready, .sts, .cmd
  );

  sbg_datapath u_dp (
    .clk, .rst_n, .dsz_512(cfg_valid && cfg_ready ? cfg_digest_size_512 : dsz_r),
    .data_byte(in_data_byte), .cmd, .sts, .digest_byte(out_digest_byte)
  );
endmodule

// ===== tb/streebog_digest_checker.sv =====
// Digest predictor and scoreboard for the Streebog hash engine
`timescale 1ns / 100ps
module streebog_digest_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_byte_valid,
  input  logic       in_message_end,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_digest_byte,
  input  logic       out_digest_last,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic       cfg_digest_size_512,
  output int         fail_count,
  output int         digest_pending
);
  import sbg_pkg::*;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } digest_word_t;

  // predicted engine state, 512-bit values with word 0 at the top
  logic         long_digest;
  blk_t         chain_h;
  blk_t         length_n;
  blk_t         sigma_sum;
  blk_t         msg_block;
  int unsigned  fill_bytes;
  digest_word_t digest_q[$];

  // S box, byte transpose and linear map in one pass
  function automatic blk_t slp_pass(input blk_t x);
    blk_t        y;
    logic [63:0] row;
    logic [63:0] acc;
    for (int r = 0; r < 8; r++) begin
      for (int c = 0; c < 8; c++) begin
        row[63-8*c -: 8] = SBOX[x[511-64*c-8*r -: 8]];
      end
      acc = '0;
      for (int b = 0; b < 64; b++) begin
        if (row[b]) acc ^= LROWS[63-b];
      end
      y[511-64*r -: 64] = acc;
    end
    return y;
  endfunction

  // g_n: new chain value from chain h, counter n and block m
  function automatic blk_t g_compress(input blk_t h, input blk_t n, input blk_t m);
    blk_t key;
    blk_t st;
    key = slp_pass(h ^ n);
    st  = key ^ m;
    for (int i = 0; i < Rounds; i++) begin
      st  = slp_pass(st);
      key = slp_pass(key ^ ICONST[i]);
      st  = st ^ key;
    end
    return h ^ st ^ m;
  endfunction

  function automatic void restart_message();
    chain_h    = long_digest ? '0 : {64{8'h01}};
    length_n   = '0;
    sigma_sum  = '0;
    msg_block  = '0;
    fill_bytes = 0;
  endfunction

  function automatic void absorb_block(input int unsigned bits);
    chain_h    = g_compress(chain_h, length_n, msg_block);
    length_n   = length_n + blk_t'(bits);
    sigma_sum  = sigma_sum + msg_block;
    msg_block  = '0;
    fill_bytes = 0;
  endfunction

  // one accepted input word
  function automatic void take_word(input logic [7:0] d, input logic bv, input logic e);
    int unsigned cnt;
    digest_word_t w;
    if (bv) begin
      msg_block[8*fill_bytes +: 8] = d;
      fill_bytes++;
      if (fill_bytes == 64) absorb_block(512);
    end
    if (e) begin
      msg_block[8*fill_bytes +: 8] = 8'h01;
      absorb_block(8 * fill_bytes);
      chain_h = g_compress(chain_h, '0, length_n);
      chain_h = g_compress(chain_h, '0, sigma_sum);
      cnt = long_digest ? 64 : 32;
      for (int k = 0; k < cnt; k++) begin
        w.value = chain_h[511-8*k -: 8];
        w.last  = (k == cnt - 1);
        digest_q.push_back(w);
      end
      restart_message();
    end
  endfunction

  always @(posedge clk) begin
    digest_word_t exp_w;
    if (!rst_n) begin
      long_digest = 1'b1;
      restart_message();
      digest_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        long_digest = cfg_digest_size_512;
        restart_message();
      end
      if (in_valid && !in_stall) take_word(in_data_byte, in_byte_valid, in_message_end);
      if (out_valid && !out_stall) begin
        if (digest_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected digest word %02h last %b", $time,
                   out_digest_byte, out_digest_last);
        end else begin
          exp_w = digest_q.pop_front();
          if (out_digest_byte !== exp_w.value) begin
            fail_count++;
            $display("%0t: digest_byte expected %02h actual %02h", $time,
                     exp_w.value, out_digest_byte);
          end
          if (out_digest_last !== exp_w.last) begin
            fail_count++;
            $display("%0t: digest_last expected %b actual %b", $time,
                     exp_w.last, out_digest_last);
          end
        end
      end
    end
    digest_pending = digest_q.size();
  end

  initial begin
    fail_count     = 0;
    digest_pending = 0;
  end

endmodule

// ===== tb/tb_streebog_hash_engine.sv =====
// Stimulus and verdict for the Streebog hash engine
`timescale 1ns / 100ps
module tb_streebog_hash_engine;

  localparam int CycleLimit = 400000;
  localparam int WordTarget = 430;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_data_byte;
  logic       in_byte_valid;
  logic       in_message_end;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_digest_byte;
  logic       out_digest_last;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_digest_size_512;

  int fail_count;
  int digest_pending;
  int cycle_count;
  int words_sent;
  int hold_reqs;
  int hold_seen;
  int hold_left;
  int stall_burst;
  bit quiet;

  streebog_hash_engine dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data_byte(in_data_byte),
    .in_byte_valid(in_byte_valid), .in_message_end(in_message_end),
    .out_valid(out_valid), .out_stall(out_stall), .out_digest_byte(out_digest_byte),
    .out_digest_last(out_digest_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_digest_size_512(cfg_digest_size_512)
  );

  streebog_digest_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data_byte(in_data_byte),
    .in_byte_valid(in_byte_valid), .in_message_end(in_message_end),
    .out_valid(out_valid), .out_stall(out_stall), .out_digest_byte(out_digest_byte),
    .out_digest_last(out_digest_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_digest_size_512(cfg_digest_size_512),
    .fail_count(fail_count), .digest_pending(digest_pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_streebog_hash_engine failed");
      $finish;
    end
  end

  // receiver: random stall bursts, long hold-off on request
  always @(negedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else if (stall_burst > 0) begin
      out_stall = 1'b1;
      stall_burst--;
    end else begin
      out_stall = 1'b0;
      if (!quiet && $urandom_range(0, 7) == 0) stall_burst = $urandom_range(1, 8);
    end
  end

  // one input word; entered just after a falling edge, leaves just after one
  task automatic send_word(input logic [7:0] d, input logic bv, input logic e);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid       = 1'b1;
    in_data_byte   = d;
    in_byte_valid  = bv;
    in_message_end = e;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (bv || e) words_sent++;
  endtask

  // message of len bytes; end on its own word when split_end or empty
  task automatic send_message(input int len, input bit split_end);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_word(8'($urandom_range(0, 255)), 1'b1, (i == len - 1) && !split_end);
    end
    if (split_end || len == 0) send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // wait for the engine to drain, then write the digest size
  task automatic write_size(input logic v);
    in_valid = 1'b0;
    while (digest_pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    cfg_valid           = 1'b1;
    cfg_digest_size_512 = v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin
    int len;
    int pick;
    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_data_byte        = '0;
    in_byte_valid       = 1'b0;
    in_message_end      = 1'b0;
    out_stall           = 1'b0;
    cfg_valid           = 1'b0;
    cfg_digest_size_512 = 1'b1;
    cycle_count = 0;
    words_sent  = 0;
    hold_reqs   = 0;
    hold_seen   = 0;
    hold_left   = 0;
    stall_burst = 0;
    quiet       = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty messages, extreme bytes, empty word, both sizes
    send_word(8'h00, 1'b0, 1'b1);
    send_word(8'hff, 1'b0, 1'b0);
    send_word(8'hff, 1'b1, 1'b1);
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'h80, 1'b0, 1'b1);
    write_size(1'b0);
    send_word(8'h5a, 1'b0, 1'b1);
    send_word(8'h00, 1'b1, 1'b1);
    send_word(8'hff, 1'b1, 1'b0);
    send_word(8'h01, 1'b1, 1'b0);
    send_word(8'h00, 1'b0, 1'b1);
    // partial message dropped by a size write
    send_word(8'h33, 1'b1, 1'b0);
    send_word(8'hcc, 1'b1, 1'b0);
    write_size(1'b1);
    send_word(8'h7e, 1'b1, 1'b1);

    // long receiver hold-off while two messages queue up behind it
    hold_reqs++;
    send_message(40, 1'b0);
    send_message(10, 1'b1);
    // sender waits for the whole digest backlog
    in_valid = 1'b0;
    while (digest_pending != 0) @(negedge clk);

    // random messages, mostly short, some at and past block boundaries
    while (words_sent < WordTarget) begin
      if (words_sent > WordTarget - 60) quiet = 1'b1;
      pick = $urandom_range(0, 9);
      if (pick < 6) len = $urandom_range(0, 20);
      else if (pick < 8) len = $urandom_range(21, 63);
      else if (pick == 8) len = $urandom_range(0, 1) ? 64 : 128;
      else len = $urandom_range(65, 140);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        send_message($urandom_range(1, 70), 1'b0);
        for (int i = 0; i < 3; i++) send_word(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        write_size(1'($urandom_range(0, 1)));
      end else begin
        send_message(len, 1'($urandom_range(0, 1)));
      end
      if (!quiet && $urandom_range(0, 5) == 0) write_size(1'($urandom_range(0, 1)));
    end

    in_valid = 1'b0;
    while (digest_pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (fail_count == 0 && digest_pending == 0) begin
      $display("tb_streebog_hash_engine passed");
    end else begin
      $display("tb_streebog_hash_engine failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sbg_pkg.sv
rtl/sbg_datapath.sv
rtl/sbg_ctrl.sv
rtl/streebog_hash_engine.sv
tb/streebog_digest_checker.sv
tb/tb_streebog_hash_engine.sv
